>>> rtl/lrz_pkg.sv
// ----------------------------------------------------------------------------
// lrz_pkg
// Shared constants for the Lorenz trajectory core: default widths, the
// configuration register map and the reset values of the coefficients.
// ----------------------------------------------------------------------------
package lrz_pkg;

  // Default number formats
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 22;
  localparam int INDEX_WIDTH_DEF   = 20;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RHO        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH = 3'd4;

  // Reset values, as integers or ratios scaled by one unit of the format
  localparam longint unsigned SIGMA_UNITS = 64'd10;
  localparam longint unsigned RHO_UNITS   = 64'd28;
  localparam longint unsigned BETA_NUM    = 64'd26666;
  localparam longint unsigned BETA_DEN    = 64'd10000;
  localparam longint unsigned DT_DEN      = 64'd1000;
  localparam longint unsigned RUN_LENGTH_RST = 64'd50000;

  // Input tdata width: the restart flag padded to one byte
  localparam int IN_DW = 8;

endpackage

>>> rtl/lrz_mul.sv
// ----------------------------------------------------------------------------
// lrz_mul
// Shared fixed point multiplier: registered signed product, then a floor
// shift by the fraction width and a clamp to the coordinate range.
// ----------------------------------------------------------------------------
module lrz_mul #(
  parameter int CW  = lrz_pkg::COORD_WIDTH_DEF,
  parameter int FB  = lrz_pkg::FRACTION_BITS_DEF,
  parameter int OPW = lrz_pkg::COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic signed [OPW-1:0] op_a,
  input  logic signed [OPW-1:0] op_b,
  output logic signed [CW-1:0]  q,
  output logic                  q_sat
);

  localparam int PW = 2 * OPW;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] shifted;
  logic [PW-CW:0]       hi_bits;
  logic                 ovf;

  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod;
  end

  // Arithmetic shift gives rounding toward minus infinity.
  assign shifted = prod_r >>> FB;
  assign hi_bits = shifted[PW-1:CW-1];
  assign ovf     = (|hi_bits) && !(&hi_bits);
  assign q_sat   = ovf;

  always_comb begin
    if (ovf) begin
      q = shifted[PW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      q = shifted[CW-1:0];
    end
  end

endmodule

>>> rtl/lorenz_euler_trajectory_core.sv
// ----------------------------------------------------------------------------
// lorenz_euler_trajectory_core
// Each input steps through PREP, MDX to MDTZ, WZ and DONE; DONE waits until
// the output register is free, then raises out_tvalid. No input is taken
// meanwhile; the seven products pass one by one through the shared multiplier.
// Reset (rst_n, synchronous): coefficients return to their defaults, the
// point to (1,1,1) and the point counter to 0; there is no clearing pass.
// ----------------------------------------------------------------------------
module lorenz_euler_trajectory_core #(
  parameter int COORD_WIDTH   = lrz_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = lrz_pkg::FRACTION_BITS_DEF,
  parameter int INDEX_WIDTH   = lrz_pkg::INDEX_WIDTH_DEF,
  localparam int CDW = (COORD_WIDTH > FRACTION_BITS + 1) ?
                       ((COORD_WIDTH > INDEX_WIDTH) ? COORD_WIDTH : INDEX_WIDTH) :
                       ((FRACTION_BITS + 1 > INDEX_WIDTH) ? FRACTION_BITS + 1 : INDEX_WIDTH),
  localparam int DW  = ((3 * COORD_WIDTH + INDEX_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lrz_pkg::IN_DW-1:0]     in_tdata,   // [0] restart
  // Result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [DW-1:0]                 out_tdata,  // point_x, point_y, point_z, step_index
  output logic                          out_tlast,  // run_end
  output logic                          out_tuser,  // saturated
  // Configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lrz_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CDW-1:0]                cfg_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = FRACTION_BITS;
  localparam int IW  = INDEX_WIDTH;
  localparam int TSW = FB + 1;
  localparam int OPW = (CW > FB + 1) ? CW : FB + 2;

  localparam longint unsigned ONE64 = 64'd1 << FB;
  localparam logic signed [CW-1:0] ONE_C     = CW'(ONE64);
  localparam logic signed [CW-1:0] SIGMA_RST = CW'(lrz_pkg::SIGMA_UNITS * ONE64);
  localparam logic signed [CW-1:0] RHO_RST   = CW'(lrz_pkg::RHO_UNITS * ONE64);
  localparam logic signed [CW-1:0] BETA_RST  =
    CW'((lrz_pkg::BETA_NUM * ONE64 + lrz_pkg::BETA_DEN - 64'd1) / lrz_pkg::BETA_DEN);
  localparam logic [TSW-1:0] DT_RST  = TSW'(ONE64 / lrz_pkg::DT_DEN);
  localparam logic [IW-1:0]  LEN_RST = IW'(lrz_pkg::RUN_LENGTH_RST);

  // Sequencer phases; each multiply phase issues one product, and the
  // following phase writes its clamped result back.
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_PREP = 4'd1;
  localparam logic [3:0] PH_MDX  = 4'd2;
  localparam logic [3:0] PH_MRZ  = 4'd3;
  localparam logic [3:0] PH_MDTX = 4'd4;
  localparam logic [3:0] PH_MXY  = 4'd5;
  localparam logic [3:0] PH_MBZ  = 4'd6;
  localparam logic [3:0] PH_MDTY = 4'd7;
  localparam logic [3:0] PH_MDTZ = 4'd8;
  localparam logic [3:0] PH_WZ   = 4'd9;
  localparam logic [3:0] PH_DONE = 4'd10;

  logic [3:0]            phase_r, phase_nxt;
  logic signed [CW-1:0]  x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [IW-1:0]         cnt_r, cnt_nxt;
  logic signed [CW-1:0]  sigma_r, sigma_nxt, beta_r, beta_nxt, rho_r, rho_nxt;
  logic [TSW-1:0]        dt_r, dt_nxt;
  logic [IW-1:0]         len_r, len_nxt;
  logic signed [CW-1:0]  d1_r, d1_nxt, d2_r, d2_nxt;
  logic signed [CW-1:0]  dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic signed [CW-1:0]  nx_r, nx_nxt, ny_r, ny_nxt, nz_r, nz_nxt;
  logic                  flag_r, flag_nxt;
  logic signed [CW-1:0]  ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic [IW-1:0]         oidx_r, oidx_nxt;
  logic                  olast_r, olast_nxt, osat_r, osat_nxt;
  logic                  ovalid_r, ovalid_nxt;

  logic signed [OPW-1:0] op_a, op_b;
  logic signed [CW-1:0]  q;
  logic                  q_sat;
  logic [IW-1:0]         len_eff;
  logic                  in_acc, cfg_acc;
  logic [CW:0]           r1, r2;

  // Saturating add or subtract; bit CW of the result is the clamp flag.
  function automatic logic [CW:0] sat_as(input logic signed [CW-1:0] a,
                                         input logic signed [CW-1:0] b,
                                         input logic sub);
    logic signed [CW:0] s;
    logic               ovf;
    s   = sub ? ((CW+1)'(a) - (CW+1)'(b)) : ((CW+1)'(a) + (CW+1)'(b));
    ovf = s[CW] ^ s[CW-1];
    return {ovf, ovf ? {s[CW], {(CW-1){~s[CW]}}} : s[CW-1:0]};
  endfunction

  lrz_mul #(
    .CW  (CW),
    .FB  (FB),
    .OPW (OPW)
  ) u_mul (
    .clk   (clk),
    .op_a  (op_a),
    .op_b  (op_b),
    .q     (q),
    .q_sat (q_sat)
  );

  assign in_tready  = (phase_r == PH_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign len_eff    = (len_r == '0) ? IW'(1) : len_r;

  assign out_tvalid = ovalid_r;
  assign out_tdata  = DW'({oidx_r, oz_r, oy_r, ox_r});
  assign out_tlast  = olast_r;
  assign out_tuser  = osat_r;

  // Operand selection for the product issued in each phase
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (phase_r)
      PH_MDX:  begin op_a = OPW'(sigma_r); op_b = OPW'(d1_r); end
      PH_MRZ:  begin op_a = OPW'(x_r);     op_b = OPW'(d2_r); end
      PH_MDTX: begin op_a = OPW'(dt_r);    op_b = OPW'(dx_r); end
      PH_MXY:  begin op_a = OPW'(x_r);     op_b = OPW'(y_r);  end
      PH_MBZ:  begin op_a = OPW'(beta_r);  op_b = OPW'(z_r);  end
      PH_MDTY: begin op_a = OPW'(dt_r);    op_b = OPW'(dy_r); end
      PH_MDTZ: begin op_a = OPW'(dt_r);    op_b = OPW'(dz_r); end
      default: begin op_a = '0;            op_b = '0;         end
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    cnt_nxt    = cnt_r;
    sigma_nxt  = sigma_r;
    beta_nxt   = beta_r;
    rho_nxt    = rho_r;
    dt_nxt     = dt_r;
    len_nxt    = len_r;
    d1_nxt     = d1_r;
    d2_nxt     = d2_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    dz_nxt     = dz_r;
    nx_nxt     = nx_r;
    ny_nxt     = ny_r;
    nz_nxt     = nz_r;
    flag_nxt   = flag_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    oz_nxt     = oz_r;
    oidx_nxt   = oidx_r;
    olast_nxt  = olast_r;
    osat_nxt   = osat_r;
    ovalid_nxt = ovalid_r && !out_tready;
    r1         = '0;
    r2         = '0;

    if (cfg_acc) begin
      unique case (cfg_index)
        lrz_pkg::REG_SIGMA:      sigma_nxt = cfg_data[CW-1:0];
        lrz_pkg::REG_BETA:       beta_nxt  = cfg_data[CW-1:0];
        lrz_pkg::REG_RHO:        rho_nxt   = cfg_data[CW-1:0];
        lrz_pkg::REG_TIME_STEP:  dt_nxt    = cfg_data[TSW-1:0];
        lrz_pkg::REG_RUN_LENGTH: len_nxt   = cfg_data[IW-1:0];
        default: ;
      endcase
    end

    unique case (phase_r)
      PH_IDLE: begin
        if (in_acc) begin
          flag_nxt  = 1'b0;
          phase_nxt = PH_PREP;
          // Restart on request, or once the point count has reached the run length.
          if (in_tdata[0] || (cnt_r >= len_eff)) begin
            x_nxt   = ONE_C;
            y_nxt   = ONE_C;
            z_nxt   = ONE_C;
            cnt_nxt = '0;
          end
        end
      end
      PH_PREP: begin
        r1        = sat_as(y_r, x_r, 1'b1);
        r2        = sat_as(rho_r, z_r, 1'b1);
        d1_nxt    = r1[CW-1:0];
        d2_nxt    = r2[CW-1:0];
        flag_nxt  = flag_r | r1[CW] | r2[CW];
        phase_nxt = PH_MDX;
      end
      PH_MDX: begin
        phase_nxt = PH_MRZ;
      end
      PH_MRZ: begin
        dx_nxt    = q;
        flag_nxt  = flag_r | q_sat;
        phase_nxt = PH_MDTX;
      end
      PH_MDTX: begin
        r1        = sat_as(q, y_r, 1'b1);
        dy_nxt    = r1[CW-1:0];
        flag_nxt  = flag_r | q_sat | r1[CW];
        phase_nxt = PH_MXY;
      end
      PH_MXY: begin
        r1        = sat_as(x_r, q, 1'b0);
        nx_nxt    = r1[CW-1:0];
        flag_nxt  = flag_r | q_sat | r1[CW];
        phase_nxt = PH_MBZ;
      end
      PH_MBZ: begin
        // x*y parks in d1, which is free by now.
        d1_nxt    = q;
        flag_nxt  = flag_r | q_sat;
        phase_nxt = PH_MDTY;
      end
      PH_MDTY: begin
        r1        = sat_as(d1_r, q, 1'b1);
        dz_nxt    = r1[CW-1:0];
        flag_nxt  = flag_r | q_sat | r1[CW];
        phase_nxt = PH_MDTZ;
      end
      PH_MDTZ: begin
        r1        = sat_as(y_r, q, 1'b0);
        ny_nxt    = r1[CW-1:0];
        flag_nxt  = flag_r | q_sat | r1[CW];
        phase_nxt = PH_WZ;
      end
      PH_WZ: begin
        r1        = sat_as(z_r, q, 1'b0);
        nz_nxt    = r1[CW-1:0];
        flag_nxt  = flag_r | q_sat | r1[CW];
        phase_nxt = PH_DONE;
      end
      PH_DONE: begin
        if (!ovalid_r || out_tready) begin
          ox_nxt     = nx_r;
          oy_nxt     = ny_r;
          oz_nxt     = nz_r;
          oidx_nxt   = cnt_r;
          olast_nxt  = ((IW+1)'(cnt_r) + (IW+1)'(1)) >= (IW+1)'(len_eff);
          osat_nxt   = flag_r;
          ovalid_nxt = 1'b1;
          x_nxt      = nx_r;
          y_nxt      = ny_r;
          z_nxt      = nz_r;
          cnt_nxt    = cnt_r + IW'(1);
          phase_nxt  = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      ovalid_r <= 1'b0;
      x_r      <= ONE_C;
      y_r      <= ONE_C;
      z_r      <= ONE_C;
      cnt_r    <= '0;
      sigma_r  <= SIGMA_RST;
      beta_r   <= BETA_RST;
      rho_r    <= RHO_RST;
      dt_r     <= DT_RST;
      len_r    <= LEN_RST;
      flag_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      ovalid_r <= ovalid_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      z_r      <= z_nxt;
      cnt_r    <= cnt_nxt;
      sigma_r  <= sigma_nxt;
      beta_r   <= beta_nxt;
      rho_r    <= rho_nxt;
      dt_r     <= dt_nxt;
      len_r    <= len_nxt;
      flag_r   <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d1_r    <= d1_nxt;
    d2_r    <= d2_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    dz_r    <= dz_nxt;
    nx_r    <= nx_nxt;
    ny_r    <= ny_nxt;
    nz_r    <= nz_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oz_r    <= oz_nxt;
    oidx_r  <= oidx_nxt;
    olast_r <= olast_nxt;
    osat_r  <= osat_nxt;
  end

endmodule

>>> rtl/lrz_checker.sv
// ----------------------------------------------------------------------------
// lrz_checker
// Port-level checks on the Lorenz trajectory core, attached by bind.
// ----------------------------------------------------------------------------
module lrz_checker #(
  parameter int DW = 16
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tvalid,
  input logic          in_tready,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [DW-1:0] out_tdata,
  input logic          out_tlast,
  input logic          out_tuser
);

  // The core works on one step at a time.
  a_busy_after_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a step was in progress");

  // Leaving a step always presents its result.
  a_result_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(in_tready)) |-> out_tvalid)
    else $error("step finished without a result");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("result changed while stalled");

endmodule

bind lorenz_euler_trajectory_core lrz_checker #(
  .DW (DW)
) u_lrz_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lorenz trajectory core testbench
// Drives restart ticks and coefficient writes into the core and checks each
// emitted point against a fixed-point Euler predictor kept in a scoreboard.
// Directed ticks cover restarts, short and zero run lengths, a run length
// lowered under the counter and saturating coefficients. Random phases then
// follow, with random stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CW = lrz_pkg::COORD_WIDTH_DEF;
  localparam int FB = lrz_pkg::FRACTION_BITS_DEF;
  localparam int IW = lrz_pkg::INDEX_WIDTH_DEF;
  localparam int TW = FB + 1;
  localparam int OUT_DW = ((3 * CW + IW + 7) / 8) * 8;
  localparam int CFG_DW = 32;
  localparam int CFG_IW = lrz_pkg::CFG_IDX_W;
  localparam int IN_W   = lrz_pkg::IN_DW;

  localparam int LATENCY        = 10;
  localparam int IDLE_PCT       = 17;
  localparam int RESTART_PCT    = 4;
  localparam int HOLD_CYCLES    = 400;
  // Longest correct quiet stretch comes from the output hold-off.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_TICKS   = 600;
  localparam int MAX_REPORTS    = 10;

  localparam longint COORD_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam int unsigned FRAC_ONE = 1 << FB;

  localparam logic [CFG_DW-1:0] SIGMA_RST   = 32'd41943040;
  localparam logic [CFG_DW-1:0] BETA_RST    = 32'd11184532;
  localparam logic [CFG_DW-1:0] RHO_RST     = 32'd117440512;
  localparam logic [CFG_DW-1:0] DT_RST      = 32'd4194;
  localparam logic [CFG_DW-1:0] RUN_LEN_RST = 32'd50000;
  localparam logic [CFG_DW-1:0] POS_MAX     = 32'h7fff_ffff;
  localparam logic [CFG_DW-1:0] NEG_MAX     = 32'h8000_0000;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [IW-1:0] index;
    logic          run_end;
    logic          saturated;
  } lorenz_point_t;

  class lorenz_scoreboard;
    logic [CW-1:0] sigma, beta, rho;
    logic [TW-1:0] time_step;
    logic [IW-1:0] run_length;
    logic [IW-1:0] point_count;
    longint        cx, cy, cz;
    bit            clamped;
    lorenz_point_t expected_points[$];
    int            mismatches, points_checked, runs_ended, saturated_points;

    function new();
      sigma = SIGMA_RST[CW-1:0];
      beta = BETA_RST[CW-1:0];
      rho = RHO_RST[CW-1:0];
      time_step = DT_RST[TW-1:0];
      run_length = RUN_LEN_RST[IW-1:0];
      cx = FRAC_ONE;
      cy = FRAC_ONE;
      cz = FRAC_ONE;
      point_count = '0;
      mismatches = 0;
      points_checked = 0;
      runs_ended = 0;
      saturated_points = 0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] index, logic [CFG_DW-1:0] data);
      case (index)
        lrz_pkg::REG_SIGMA: sigma = data[CW-1:0];
        lrz_pkg::REG_BETA: beta = data[CW-1:0];
        lrz_pkg::REG_RHO: rho = data[CW-1:0];
        lrz_pkg::REG_TIME_STEP: time_step = data[TW-1:0];
        lrz_pkg::REG_RUN_LENGTH: run_length = data[IW-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v);
      if (v > COORD_MAX) begin
        clamped = 1'b1;
        return COORD_MAX;
      end
      if (v < COORD_MIN) begin
        clamped = 1'b1;
        return COORD_MIN;
      end
      return v;
    endfunction

    // Operands never exceed 32 bits, so the exact product fits in 64 bits and
    // the arithmetic shift floors it.
    function longint fix_mul(longint a, longint b);
      return clamp((a * b) >>> FB);
    endfunction

    function void note_tick(logic restart);
      longint x, y, z, dx, dy, dz;
      int len;
      lorenz_point_t p;
      len = (run_length == 0) ? 1 : int'(run_length);
      if (restart || int'(point_count) >= len) begin
        cx = FRAC_ONE;
        cy = FRAC_ONE;
        cz = FRAC_ONE;
        point_count = '0;
      end
      clamped = 1'b0;
      x = cx;
      y = cy;
      z = cz;
      dx = fix_mul(longint'($signed(sigma)), clamp(y - x));
      dy = clamp(fix_mul(x, clamp(longint'($signed(rho)) - z)) - y);
      dz = clamp(fix_mul(x, y) - fix_mul(longint'($signed(beta)), z));
      cx = clamp(x + fix_mul(longint'(time_step), dx));
      cy = clamp(y + fix_mul(longint'(time_step), dy));
      cz = clamp(z + fix_mul(longint'(time_step), dz));
      p.x = CW'(cx);
      p.y = CW'(cy);
      p.z = CW'(cz);
      p.index = point_count;
      p.run_end = (int'(point_count) + 1 >= len);
      p.saturated = clamped;
      point_count = point_count + 1'b1;
      expected_points.push_back(p);
    endfunction

    function void check_point(lorenz_point_t got);
      lorenz_point_t want;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] point with no tick pending: x=%h y=%h z=%h idx=%0d",
                   $time, got.x, got.y, got.z, got.index);
        return;
      end
      want = expected_points.pop_front();
      points_checked++;
      if (want.run_end) runs_ended++;
      if (want.saturated) saturated_points++;
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.index !== want.index || got.run_end !== want.run_end ||
          got.saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] point %0d mismatch", $time, points_checked);
          $display("  expected x=%h y=%h z=%h idx=%0d end=%b sat=%b",
                   want.x, want.y, want.z, want.index, want.run_end, want.saturated);
          $display("  actual   x=%h y=%h z=%h idx=%0d end=%b sat=%b",
                   got.x, got.y, got.z, got.index, got.run_end, got.saturated);
        end
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_DW-1:0]    out_tdata;
  logic                 out_tlast;
  logic                 out_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IW-1:0]    cfg_index;
  logic [CFG_DW-1:0]    cfg_data;

  lorenz_scoreboard sb;
  bit pace;
  int hold_requests;
  int hold_seen;
  int hold_left;
  int quiet_cycles;
  int ticks_sent;
  int phase;

  lorenz_euler_trajectory_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin : monitor
    lorenz_point_t seen;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_tick(in_tdata[0]);
      if (out_tvalid && out_tready) begin
        seen.x = out_tdata[CW-1:0];
        seen.y = out_tdata[2*CW-1:CW];
        seen.z = out_tdata[3*CW-1:2*CW];
        seen.index = out_tdata[3*CW+IW-1:3*CW];
        seen.run_end = out_tlast;
        seen.saturated = out_tuser;
        sb.check_point(seen);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    out_tready = 1'b0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(pace && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Leaves in_tvalid high so that back-to-back ticks keep it asserted.
  task automatic send_tick(input logic [IN_W-1:0] data);
    while (pace && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  task automatic send_ticks(input int count);
    repeat (count)
      send_tick({7'($urandom), 1'($urandom_range(99) < RESTART_PCT)});
    in_tvalid <= 1'b0;
  endtask

  task automatic cfg_write(input logic [CFG_IW-1:0] index,
                           input logic [CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_coefs(input logic [CFG_DW-1:0] sg, input logic [CFG_DW-1:0] bt,
                               input logic [CFG_DW-1:0] rh, input logic [CFG_DW-1:0] dt,
                               input logic [CFG_DW-1:0] len);
    cfg_write(lrz_pkg::REG_SIGMA, sg);
    cfg_write(lrz_pkg::REG_BETA, bt);
    cfg_write(lrz_pkg::REG_RHO, rh);
    cfg_write(lrz_pkg::REG_TIME_STEP, dt);
    cfg_write(lrz_pkg::REG_RUN_LENGTH, len);
    cfg_valid <= 1'b0;
  endtask

  // Every tick yields a point, so an empty scoreboard means the core is idle.
  task automatic wait_drained();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [CFG_DW-1:0] random_coef(logic [CFG_DW-1:0] nominal);
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? POS_MAX : NEG_MAX;
      default: return nominal + $urandom_range(2 * FRAC_ONE) - FRAC_ONE;
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] random_dt();
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom;
      2: return FRAC_ONE;
      3, 4: return $urandom_range(200000, 20000);
      default: return $urandom_range(12000, 1000);
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] random_run_length();
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom;
      default: return $urandom_range(80, 1);
    endcase
  endfunction

  initial begin : stimulus
    int target;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pace = 1'b1;
    hold_requests = 0;
    ticks_sent = 0;
    phase = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset coefficients; restart with and without the unused bits set.
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'hfe);
    send_tick(8'h01);
    send_tick(8'hff);
    in_tvalid <= 1'b0;
    wait_drained();

    // Runs of one point, and a zero length that behaves as one.
    cfg_write(lrz_pkg::REG_RUN_LENGTH, 32'd1);
    cfg_valid <= 1'b0;
    send_tick(8'h00);
    send_tick(8'h00);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_write(lrz_pkg::REG_RUN_LENGTH, 32'd0);
    cfg_valid <= 1'b0;
    send_tick(8'h00);
    send_tick(8'h00);
    in_tvalid <= 1'b0;
    wait_drained();

    // Shortening the run below the current count forces a restart.
    cfg_write(lrz_pkg::REG_RUN_LENGTH, 32'd5);
    cfg_valid <= 1'b0;
    send_tick(8'h01);
    send_tick(8'h00);
    send_tick(8'h00);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_write(lrz_pkg::REG_RUN_LENGTH, 32'd2);
    cfg_valid <= 1'b0;
    send_tick(8'h00);
    send_tick(8'h00);
    in_tvalid <= 1'b0;
    wait_drained();

    // Extreme coefficients drive the datapath into saturation.
    program_coefs(POS_MAX, NEG_MAX, NEG_MAX, FRAC_ONE, 32'h000f_ffff);
    send_tick(8'h01);
    send_tick(8'h00);
    send_tick(8'h00);
    in_tvalid <= 1'b0;
    wait_drained();

    // Unmapped indexes must be ignored; oversized data is truncated.
    for (int i = int'(lrz_pkg::REG_RUN_LENGTH) + 1; i < (1 << CFG_IW); i++)
      cfg_write(CFG_IW'(i), '1);
    program_coefs(NEG_MAX, POS_MAX, POS_MAX, '1, '1);
    send_tick(8'h01);
    send_tick(8'h00);
    send_tick(8'h00);
    in_tvalid <= 1'b0;
    wait_drained();

    // A zero time step leaves the point where it is.
    cfg_write(lrz_pkg::REG_TIME_STEP, '0);
    cfg_valid <= 1'b0;
    send_tick(8'h01);
    in_tvalid <= 1'b0;

    target = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < target) begin
      wait_drained();
      pace = (phase != 2);
      if (phase == 0)
        program_coefs(SIGMA_RST, BETA_RST, RHO_RST, DT_RST, 32'd30);
      else
        program_coefs(random_coef(SIGMA_RST), random_coef(BETA_RST), random_coef(RHO_RST),
                      random_dt(), random_run_length());
      if (phase == 4) hold_requests++;
      send_ticks($urandom_range(75, 45));
      phase++;
    end
    pace = 1'b1;

    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    $display("Run covered %0d ticks in %0d random phases after the directed set.",
             ticks_sent, phase);
    $display("Checked %0d points: %0d ended a run, %0d saturated, %0d mismatches.",
             sb.points_checked, sb.runs_ended, sb.saturated_points, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lrz_pkg.sv
rtl/lrz_mul.sv
rtl/lorenz_euler_trajectory_core.sv
rtl/lrz_checker.sv
tb/testbench.sv
